@@ rtl/core/ups_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ups_pkg - shared types and constants for the URI path splitter
// Parse phases, result bundle and the character constants of the scheme.
// ----------------------------------------------------------------------------
package ups_pkg;

    localparam int LEN_W = 10;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    // last index of the scheme text
    localparam logic [LEN_W-1:0] SCHEME_LAST = LEN_W'(6);

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_HOST   = 3'd1,
        PH_APP    = 3'd2,
        PH_RUNNER = 3'd3,
        PH_FOURTH = 3'd4,
        PH_PAGE   = 3'd5,
        PH_DONE   = 3'd6,
        PH_FAIL   = 3'd7
    } t_phase;

    typedef struct packed {
        logic             valid_res;
        logic [LEN_W-1:0] host_size;
        logic [LEN_W-1:0] app_size;
        logic [LEN_W-1:0] runner_size;
        logic [LEN_W-1:0] group_size;
        logic [LEN_W-1:0] page_size;
    } t_result;

    // expected lower-case scheme character at a prefix position
    function automatic logic [7:0] scheme_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h68;
            3'd1:    c = 8'h76;
            3'd2:    c = 8'h6D;
            3'd3:    c = 8'h6C;
            3'd4:    c = 8'h3A;
            3'd5:    c = 8'h2F;
            3'd6:    c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c | 8'h20;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/uri_path_splitter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uri_path_splitter_core - URI path splitter, one byte per cycle unless stalled
// Checks the scheme, splits host, app, runner, group and page, and
// returns one verdict with the component lengths per terminated URI.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------
//  in      | i_in_valid / o_in_stall    | i_ch
//  out     | o_out_valid / i_out_stall  | o_valid_res, o_*_size (5 lengths)
//
//  One byte is taken per cycle while the input is not stalled; a verdict
//  follows its zero byte through the input register, then the result register.
//  The parse state updates in a single pass per byte, so bytes stream back
//  to back. A stall on the output holds the verdict and backs up the input
//  only when a zero byte meets a full result register that is stalled.
//  Reset is synchronous and clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
module uri_path_splitter_core #(
    parameter int MAX_URI = 1024
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_ch,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_valid_res,
    output logic [ups_pkg::LEN_W-1:0]        o_host_size,
    output logic [ups_pkg::LEN_W-1:0]        o_app_size,
    output logic [ups_pkg::LEN_W-1:0]        o_runner_size,
    output logic [ups_pkg::LEN_W-1:0]        o_group_size,
    output logic [ups_pkg::LEN_W-1:0]        o_page_size
);

    logic             r_in_valid;
    logic [7:0]       r_ch;
    logic             r_out_valid;
    ups_pkg::t_result r_res;
    ups_pkg::t_result parse_res;
    logic             is_term;
    logic             out_free;
    logic             step;

    assign is_term  = (r_ch == ups_pkg::CH_NUL);
    assign out_free = !r_out_valid || !i_out_stall;
    // advance the held request unless it is a terminator with nowhere to go
    assign step       = r_in_valid && (!is_term || out_free);
    assign o_in_stall = r_in_valid && !step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_ch <= i_ch;
        end
    end

    ups_parser #(
        .MAX_URI (MAX_URI)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_ch    (r_ch),
        .o_res   (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && is_term) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && is_term) begin
            r_res <= parse_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_valid_res   = r_res.valid_res;
    assign o_host_size   = r_res.host_size;
    assign o_app_size    = r_res.app_size;
    assign o_runner_size = r_res.runner_size;
    assign o_group_size  = r_res.group_size;
    assign o_page_size   = r_res.page_size;

endmodule
`default_nettype wire

@@ rtl/core/ups_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ups_parser - per-byte parse state of the URI path splitter
// Advances the component state on each non-zero byte, offers the verdict
// for the current state and clears itself on the terminating byte.
// ----------------------------------------------------------------------------
module ups_parser #(
    parameter int MAX_URI = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic [7:0]         i_ch,
    output ups_pkg::t_result        o_res
);

    localparam int CntW = $clog2(MAX_URI + 2);
    localparam int LW   = ups_pkg::LEN_W;

    ups_pkg::t_phase r_phase, n_phase;
    logic [CntW-1:0] r_byte_count, n_byte_count;
    logic [LW-1:0]   r_cur_len, n_cur_len;
    logic [LW-1:0]   r_q_len, n_q_len;
    logic            r_q_seen, n_q_seen;
    logic [LW-1:0]   r_host, n_host;
    logic [LW-1:0]   r_app, n_app;
    logic [LW-1:0]   r_runner, n_runner;
    logic [LW-1:0]   r_group, n_group;

    logic [7:0] lc;
    logic       is_slash;
    logic       is_quest;

    assign lc       = ups_pkg::to_lower(i_ch);
    assign is_slash = (i_ch == ups_pkg::CH_SLASH);
    assign is_quest = (i_ch == ups_pkg::CH_QUEST);

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_cur_len    = r_cur_len;
        n_q_len      = r_q_len;
        n_q_seen     = r_q_seen;
        n_host       = r_host;
        n_app        = r_app;
        n_runner     = r_runner;
        n_group      = r_group;

        if (i_ch == ups_pkg::CH_NUL) begin
            // terminator: verdict is taken, start over
            n_phase      = ups_pkg::PH_PREFIX;
            n_byte_count = '0;
            n_cur_len    = '0;
            n_q_len      = '0;
            n_q_seen     = 1'b0;
            n_host       = '0;
            n_app        = '0;
            n_runner     = '0;
            n_group      = '0;
        end else begin
            if (r_byte_count <= CntW'(MAX_URI)) begin
                n_byte_count = r_byte_count + 1'b1;
            end
            unique case (r_phase)
                ups_pkg::PH_PREFIX: begin
                    if (r_cur_len > ups_pkg::SCHEME_LAST ||
                        lc != ups_pkg::scheme_char(r_cur_len[2:0])) begin
                        n_phase = ups_pkg::PH_FAIL;
                    end else if (r_cur_len == ups_pkg::SCHEME_LAST) begin
                        n_cur_len = '0;
                        n_phase   = ups_pkg::PH_HOST;
                    end else begin
                        n_cur_len = r_cur_len + 1'b1;
                    end
                end
                ups_pkg::PH_HOST, ups_pkg::PH_APP, ups_pkg::PH_RUNNER: begin
                    if (is_slash) begin
                        if (r_cur_len == '0) begin
                            n_phase = ups_pkg::PH_FAIL;
                        end else begin
                            n_cur_len = '0;
                            if (r_phase == ups_pkg::PH_HOST) begin
                                n_host  = r_cur_len;
                                n_phase = ups_pkg::PH_APP;
                            end else if (r_phase == ups_pkg::PH_APP) begin
                                n_app   = r_cur_len;
                                n_phase = ups_pkg::PH_RUNNER;
                            end else begin
                                n_runner = r_cur_len;
                                n_phase  = ups_pkg::PH_FOURTH;
                            end
                        end
                    end else if (r_cur_len == ups_pkg::LEN_MAX) begin
                        n_phase = ups_pkg::PH_FAIL;
                    end else begin
                        n_cur_len = r_cur_len + 1'b1;
                    end
                end
                ups_pkg::PH_FOURTH: begin
                    if (is_slash) begin
                        n_q_len = '0;
                        if (r_cur_len == '0) begin
                            n_phase = ups_pkg::PH_DONE;
                        end else begin
                            n_group   = r_cur_len;
                            n_cur_len = '0;
                            n_q_seen  = 1'b0;
                            n_phase   = ups_pkg::PH_PAGE;
                        end
                    end else begin
                        // first '?' marks where a page would be cut
                        if (is_quest && !r_q_seen) begin
                            n_q_seen = 1'b1;
                            n_q_len  = r_cur_len;
                        end
                        if (r_cur_len == ups_pkg::LEN_MAX) begin
                            n_phase = ups_pkg::PH_FAIL;
                        end else begin
                            n_cur_len = r_cur_len + 1'b1;
                        end
                    end
                end
                ups_pkg::PH_PAGE: begin
                    if (is_slash) begin
                        n_phase = ups_pkg::PH_FAIL;
                    end else if (is_quest) begin
                        if (r_cur_len == '0) begin
                            n_phase = ups_pkg::PH_FAIL;
                        end else begin
                            n_q_len = r_cur_len;
                            n_phase = ups_pkg::PH_DONE;
                        end
                    end else if (r_cur_len == ups_pkg::LEN_MAX) begin
                        n_phase = ups_pkg::PH_FAIL;
                    end else begin
                        n_cur_len = r_cur_len + 1'b1;
                    end
                end
                default: begin
                    // done or failed: drop the byte
                end
            endcase
        end
    end

    // verdict for the state as it stands
    always_comb begin
        logic          ok;
        logic [LW-1:0] page;
        ok   = 1'b0;
        page = '0;
        unique case (r_phase)
            ups_pkg::PH_FOURTH: begin
                if (r_cur_len == '0) begin
                    ok = 1'b1;
                end else begin
                    page = r_q_seen ? r_q_len : r_cur_len;
                    ok   = (page != '0);
                end
            end
            ups_pkg::PH_PAGE: begin
                page = r_cur_len;
                ok   = (page != '0);
            end
            ups_pkg::PH_DONE: begin
                page = r_q_len;
                ok   = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        if (r_byte_count > CntW'(MAX_URI)) begin
            ok = 1'b0;
        end
        o_res.valid_res   = ok;
        o_res.host_size   = ok ? r_host   : '0;
        o_res.app_size    = ok ? r_app    : '0;
        o_res.runner_size = ok ? r_runner : '0;
        o_res.group_size  = ok ? r_group  : '0;
        o_res.page_size   = ok ? page     : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ups_pkg::PH_PREFIX;
            r_byte_count <= '0;
            r_cur_len    <= '0;
            r_q_len      <= '0;
            r_q_seen     <= 1'b0;
            r_host       <= '0;
            r_app        <= '0;
            r_runner     <= '0;
            r_group      <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_cur_len    <= n_cur_len;
            r_q_len      <= n_q_len;
            r_q_seen     <= n_q_seen;
            r_host       <= n_host;
            r_app        <= n_app;
            r_runner     <= n_runner;
            r_group      <= n_group;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ups_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ups_checker - port-level checks for the URI path splitter
// Watches the result channel for held requests and consistent verdicts.
// ----------------------------------------------------------------------------
module ups_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic                       o_valid_res,
    input wire logic [ups_pkg::LEN_W-1:0]  o_host_size,
    input wire logic [ups_pkg::LEN_W-1:0]  o_app_size,
    input wire logic [ups_pkg::LEN_W-1:0]  o_runner_size,
    input wire logic [ups_pkg::LEN_W-1:0]  o_group_size,
    input wire logic [ups_pkg::LEN_W-1:0]  o_page_size
);

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_valid_res) &&
        $stable(o_host_size) && $stable(o_page_size) && $stable(o_group_size))
        else $error("stalled verdict changed");

    // a rejected URI carries no lengths
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_res |-> o_host_size == '0 && o_app_size == '0 &&
        o_runner_size == '0 && o_group_size == '0 && o_page_size == '0)
        else $error("lengths on invalid verdict");

    // an accepted URI always has the three leading components
    a_valid_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_valid_res |->
        o_host_size != '0 && o_app_size != '0 && o_runner_size != '0)
        else $error("empty leading component on valid verdict");

    // a group must be followed by a page
    a_group_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_valid_res && o_group_size != '0 |-> o_page_size != '0)
        else $error("group without page");

endmodule

bind uri_path_splitter_core ups_checker u_ups_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_valid_res   (o_valid_res),
    .o_host_size   (o_host_size),
    .o_app_size    (o_app_size),
    .o_runner_size (o_runner_size),
    .o_group_size  (o_group_size),
    .o_page_size   (o_page_size)
);
`default_nettype wire

@@ tb/sv/uri_path_splitter_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uri_path_splitter_core_test - self-checking bench for the URI splitter
// Streams URIs byte by byte with random idle and stall bursts, predicts
// each verdict and its component lengths, and checks every result in order.
// ----------------------------------------------------------------------------

// scheme prefix, lower case, one byte per position
function automatic logic [7:0] scheme_byte(int idx);
    logic [55:0] txt;
    txt = 56'h68766D6C3A2F2F;
    return txt[55 - 8*idx -: 8];
endfunction

class uri_verdict_board #(int URI_LIMIT = 1024);
    ups_pkg::t_phase                phase;
    logic [10:0]                    uri_bytes;
    logic [ups_pkg::LEN_W-1:0]      open_len;
    logic [ups_pkg::LEN_W-1:0]      page_mark;
    logic                           mark_seen;
    logic [ups_pkg::LEN_W-1:0]      host_l;
    logic [ups_pkg::LEN_W-1:0]      app_l;
    logic [ups_pkg::LEN_W-1:0]      runner_l;
    logic [ups_pkg::LEN_W-1:0]      group_l;
    ups_pkg::t_result               verdict_q[$];
    int                             errors;

    function new();
        errors = 0;
        clear_parse();
    endfunction

    function void clear_parse();
        phase     = ups_pkg::PH_PREFIX;
        uri_bytes = '0;
        open_len  = '0;
        page_mark = '0;
        mark_seen = 1'b0;
        host_l    = '0;
        app_l     = '0;
        runner_l  = '0;
        group_l   = '0;
    endfunction

    function int pending();
        return verdict_q.size();
    endfunction

    function void extend();
        if (open_len >= ups_pkg::LEN_MAX) begin
            phase = ups_pkg::PH_FAIL;
        end else begin
            open_len++;
        end
    endfunction

    function void close_part(ups_pkg::t_phase nxt);
        if (open_len == 0) begin
            phase = ups_pkg::PH_FAIL;
        end else begin
            case (phase)
                ups_pkg::PH_HOST: host_l   = open_len;
                ups_pkg::PH_APP:  app_l    = open_len;
                default:          runner_l = open_len;
            endcase
            open_len = '0;
            phase    = nxt;
        end
    endfunction

    function void close_uri();
        ups_pkg::t_result          v;
        logic                      ok;
        logic [ups_pkg::LEN_W-1:0] page;
        ok   = 1'b0;
        page = '0;
        case (phase)
            ups_pkg::PH_FOURTH: begin
                if (open_len == 0) begin
                    ok = 1'b1;
                end else begin
                    page = mark_seen ? page_mark : open_len;
                    ok   = (page != 0);
                end
            end
            ups_pkg::PH_PAGE: begin
                page = open_len;
                ok   = (page != 0);
            end
            ups_pkg::PH_DONE: begin
                page = page_mark;
                ok   = 1'b1;
            end
            default: ;
        endcase
        if (uri_bytes > URI_LIMIT) begin
            ok = 1'b0;
        end
        v = '0;
        if (ok) begin
            v.valid_res   = 1'b1;
            v.host_size   = host_l;
            v.app_size    = app_l;
            v.runner_size = runner_l;
            v.group_size  = group_l;
            v.page_size   = page;
        end
        verdict_q.push_back(v);
        clear_parse();
    endfunction

    function void take_byte(logic [7:0] c);
        logic [7:0] lc;
        if (c == ups_pkg::CH_NUL) begin
            close_uri();
            return;
        end
        if (uri_bytes <= URI_LIMIT) begin
            uri_bytes++;
        end
        case (phase)
            ups_pkg::PH_PREFIX: begin
                lc = (c >= ups_pkg::CH_UP_A && c <= ups_pkg::CH_UP_Z) ? (c | 8'h20) : c;
                if (open_len > ups_pkg::SCHEME_LAST) begin
                    phase = ups_pkg::PH_FAIL;
                end else if (lc != scheme_byte(int'(open_len))) begin
                    phase = ups_pkg::PH_FAIL;
                end else if (open_len == ups_pkg::SCHEME_LAST) begin
                    open_len = '0;
                    phase    = ups_pkg::PH_HOST;
                end else begin
                    open_len++;
                end
            end
            ups_pkg::PH_HOST: begin
                if (c == ups_pkg::CH_SLASH) close_part(ups_pkg::PH_APP); else extend();
            end
            ups_pkg::PH_APP: begin
                if (c == ups_pkg::CH_SLASH) close_part(ups_pkg::PH_RUNNER); else extend();
            end
            ups_pkg::PH_RUNNER: begin
                if (c == ups_pkg::CH_SLASH) close_part(ups_pkg::PH_FOURTH); else extend();
            end
            ups_pkg::PH_FOURTH: begin
                if (c == ups_pkg::CH_SLASH) begin
                    if (open_len == 0) begin
                        page_mark = '0;
                        phase     = ups_pkg::PH_DONE;
                    end else begin
                        group_l   = open_len;
                        open_len  = '0;
                        page_mark = '0;
                        mark_seen = 1'b0;
                        phase     = ups_pkg::PH_PAGE;
                    end
                end else begin
                    // first '?' marks where a page would end
                    if (c == ups_pkg::CH_QUEST && !mark_seen) begin
                        mark_seen = 1'b1;
                        page_mark = open_len;
                    end
                    extend();
                end
            end
            ups_pkg::PH_PAGE: begin
                if (c == ups_pkg::CH_SLASH) begin
                    phase = ups_pkg::PH_FAIL;
                end else if (c == ups_pkg::CH_QUEST) begin
                    if (open_len == 0) begin
                        phase = ups_pkg::PH_FAIL;
                    end else begin
                        page_mark = open_len;
                        phase     = ups_pkg::PH_DONE;
                    end
                end else begin
                    extend();
                end
            end
            default: ;
        endcase
    endfunction

    task report(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task cmp_field(string name, int got, int want);
        if (got != want) begin
            report($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    task check_verdict(ups_pkg::t_result got);
        ups_pkg::t_result want;
        if (verdict_q.size() == 0) begin
            report($sformatf("verdict %h with nothing pending", got));
            return;
        end
        want = verdict_q.pop_front();
        cmp_field("valid_res", got.valid_res, want.valid_res);
        cmp_field("host_size", got.host_size, want.host_size);
        cmp_field("app_size", got.app_size, want.app_size);
        cmp_field("runner_size", got.runner_size, want.runner_size);
        cmp_field("group_size", got.group_size, want.group_size);
        cmp_field("page_size", got.page_size, want.page_size);
    endtask
endclass

module uri_path_splitter_core_test;

    localparam int MAX_URI     = 1024;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_BYTES  = 680;
    localparam int CALM_BYTES  = 540;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [7:0]                i_ch;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic                      o_valid_res;
    logic [ups_pkg::LEN_W-1:0] o_host_size;
    logic [ups_pkg::LEN_W-1:0] o_app_size;
    logic [ups_pkg::LEN_W-1:0] o_runner_size;
    logic [ups_pkg::LEN_W-1:0] o_group_size;
    logic [ups_pkg::LEN_W-1:0] o_page_size;

    uri_verdict_board #(.URI_LIMIT(MAX_URI)) board;
    ups_pkg::t_result seen_verdict;
    logic [7:0]       uri_q[$];
    bit               idle_on;
    int               stall_left;
    int               rand_bytes;
    int               uri_count;
    int               cycles;

    uri_path_splitter_core #(
        .MAX_URI(MAX_URI)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_ch(i_ch),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_valid_res(o_valid_res),
        .o_host_size(o_host_size),
        .o_app_size(o_app_size),
        .o_runner_size(o_runner_size),
        .o_group_size(o_group_size),
        .o_page_size(o_page_size)
    );

    always #5 i_clk = ~i_clk;

    // output backpressure in random bursts, started only while idle_on is set
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_verdict.valid_res   = o_valid_res;
            seen_verdict.host_size   = o_host_size;
            seen_verdict.app_size    = o_app_size;
            seen_verdict.runner_size = o_runner_size;
            seen_verdict.group_size  = o_group_size;
            seen_verdict.page_size   = o_page_size;
            board.check_verdict(seen_verdict);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("uri_path_splitter_core_test: FAIL");
        $finish;
    end

    function automatic logic [7:0] text_byte(bit allow_quest);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b == ups_pkg::CH_SLASH || (!allow_quest && b == ups_pkg::CH_QUEST));
        return b;
    endfunction

    function void put_text(int n, bit allow_quest);
        repeat (n) uri_q.push_back(text_byte(allow_quest));
    endfunction

    function void put_any(int n);
        repeat (n) uri_q.push_back(8'($urandom_range(1, 255)));
    endfunction

    function void put_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            uri_q.push_back(s[i]);
        end
    endfunction

    function void put_scheme(bit upper_all, bit spoil);
        int         bad;
        logic [7:0] b;
        bad = spoil ? int'($urandom_range(0, 6)) : -1;
        for (int i = 0; i < 7; i++) begin
            b = scheme_byte(i);
            if (i < 4 && (upper_all || $urandom_range(0, 1) == 1)) begin
                b = b & 8'hDF;
            end
            if (i == bad) begin
                b = b ^ 8'($urandom_range(1, 255));
            end
            uri_q.push_back(b);
        end
    endfunction

    function int part_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 0;
        if (r < 8) return $urandom_range(20, 60);
        return $urandom_range(1, 6);
    endfunction

    function void put_slash();
        uri_q.push_back(ups_pkg::CH_SLASH);
    endfunction

    function void put_quest();
        uri_q.push_back(ups_pkg::CH_QUEST);
    endfunction

    function void make_uri();
        bit broken;
        int cut;
        uri_q.delete();
        if ($urandom_range(0, 19) == 0) begin
            put_any($urandom_range(0, 20));
        end else begin
            broken = ($urandom_range(0, 9) == 0);
            put_scheme(1'b0, broken && $urandom_range(0, 1) == 1);
            repeat (3) begin
                put_text(part_len(), 1'b1);
                put_slash();
            end
            case ($urandom_range(0, 8))
                0: ;
                1: begin
                    put_text($urandom_range(1, 8), 1'b0);
                    if ($urandom_range(0, 1) == 1) begin
                        put_quest();
                        put_text($urandom_range(0, 5), 1'b1);
                    end
                end
                2: begin
                    put_quest();
                    put_text($urandom_range(0, 4), 1'b1);
                end
                3: begin
                    put_slash();
                    put_any($urandom_range(0, 6));
                end
                4: begin
                    put_text($urandom_range(1, 6), 1'b0);
                    put_slash();
                    put_text($urandom_range(1, 8), 1'b0);
                end
                5: begin
                    put_text($urandom_range(1, 6), 1'b0);
                    put_slash();
                    put_text($urandom_range(1, 8), 1'b0);
                    put_quest();
                    put_any($urandom_range(0, 6));
                end
                6: begin
                    put_text($urandom_range(1, 6), 1'b0);
                    put_slash();
                    if ($urandom_range(0, 1) == 1) begin
                        put_quest();
                        put_any($urandom_range(0, 3));
                    end
                end
                7: begin
                    put_text($urandom_range(1, 6), 1'b0);
                    put_slash();
                    put_text($urandom_range(1, 8), 1'b0);
                    put_slash();
                    put_any($urandom_range(0, 3));
                end
                default: begin
                    put_text($urandom_range(0, 3), 1'b0);
                    put_quest();
                    put_text($urandom_range(0, 3), 1'b1);
                    put_slash();
                    put_text($urandom_range(1, 6), 1'b0);
                end
            endcase
            // end the URI early
            if (broken && uri_q.size() > 0) begin
                cut = $urandom_range(0, uri_q.size() - 1);
                while (uri_q.size() > cut) void'(uri_q.pop_back());
            end
        end
        uri_q.push_back(ups_pkg::CH_NUL);
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? int'($urandom_range(1, 4)) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= b;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        board.take_byte(b);
        @(negedge i_clk);
    endtask

    task automatic ship_uri();
        uri_q.push_back(ups_pkg::CH_NUL);
        foreach (uri_q[i]) send_byte(uri_q[i]);
        uri_q.delete();
    endtask

    task automatic send_random_uri();
        make_uri();
        foreach (uri_q[i]) send_byte(uri_q[i]);
        rand_bytes += uri_q.size();
        uri_q.delete();
    endtask

    // hold the input until every pending verdict has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (board.pending() != 0);
    endtask

    task automatic run_directed();
        put_scheme(1'b0, 1'b0); put_str("a/b/c/"); ship_uri();
        put_scheme(1'b1, 1'b0); put_str("host/app/run/page"); ship_uri();
        put_scheme(1'b0, 1'b0); put_str("h/a/r/p?q=1/x"); ship_uri();
        put_scheme(1'b0, 1'b0); put_str("h/a/r/g/p"); ship_uri();
        put_scheme(1'b0, 1'b0); put_str("h/a/r/g/pg?z/z"); ship_uri();
        put_scheme(1'b0, 1'b0); put_str("h/a/r//j?/k"); ship_uri();
        put_scheme(1'b0, 1'b0); put_str("h/a/r/?x"); ship_uri();
        put_scheme(1'b0, 1'b0); put_str("h/a/r/g/p/"); ship_uri();
        put_scheme(1'b0, 1'b0); put_str("h/a/r/g/"); ship_uri();
        put_scheme(1'b0, 1'b0); put_str("h/a/r/g/?p"); ship_uri();
        put_scheme(1'b0, 1'b0); put_str("h/a"); ship_uri();
        put_scheme(1'b0, 1'b0); put_str("/a/r/"); ship_uri();
        put_scheme(1'b0, 1'b1); put_str("h/a/r/"); ship_uri();
        ship_uri();
        // extreme byte values inside components
        put_scheme(1'b0, 1'b0);
        uri_q.push_back(8'hFF); put_slash();
        uri_q.push_back(8'h80); put_slash();
        uri_q.push_back(8'h01); uri_q.push_back(8'h7F); put_slash();
        uri_q.push_back(8'hFE);
        ship_uri();
        // one byte past the URI length limit
        put_scheme(1'b0, 1'b0); put_text(1000, 1'b1); put_str("/a/r/");
        put_text(13, 1'b0); ship_uri();
    endtask

    initial begin
        board       = new();
        idle_on     = 1'b0;
        stall_left  = 0;
        rand_bytes  = 0;
        uri_count   = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_ch        = 8'h00;
        i_out_stall = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_on = 1'b1;
        run_directed();
        drain();

        while (rand_bytes < RAND_BYTES) begin
            idle_on = (rand_bytes < CALM_BYTES) && ($urandom_range(0, 3) != 0);
            send_random_uri();
            uri_count++;
            if (uri_count % 20 == 19) begin
                drain();
            end
        end

        idle_on = 1'b0;
        drain();
        repeat (8) @(negedge i_clk);
        if (board.errors == 0) begin
            $display("uri_path_splitter_core_test: PASS");
        end else begin
            $display("uri_path_splitter_core_test: FAIL");
        end
        $finish;
    end

endmodule
